@@ sv/tssr_pkg.sv @@
// ----------------------------------------------------------------------------
// tssr_pkg
// Shared types, codes and helpers for the slot statistics and reconfig unit
// ----------------------------------------------------------------------------
package tssr_pkg;

  localparam int NUM_SLOTS_DEF    = 32;
  localparam int NUM_CHANNELS_DEF = 16;

  // command codes
  localparam logic [2:0] CMD_TX     = 3'd0;
  localparam logic [2:0] CMD_RX     = 3'd1;
  localparam logic [2:0] CMD_COLL   = 3'd2;
  localparam logic [2:0] CMD_RCFG   = 3'd3;
  localparam logic [2:0] CMD_RSTAT  = 3'd4;
  localparam logic [2:0] CMD_RESIZE = 3'd5;
  localparam logic [2:0] CMD_QUERY  = 3'd6;
  localparam logic [2:0] CMD_NOP    = 3'd7;

  // result kinds
  localparam logic [2:0] EV_ACK   = 3'd0;
  localparam logic [2:0] EV_DEACT = 3'd1;
  localparam logic [2:0] EV_DED   = 3'd2;
  localparam logic [2:0] EV_CHAN  = 3'd3;
  localparam logic [2:0] EV_DONE  = 3'd4;

  // slot modes
  localparam logic [2:0] MODE_INACTIVE = 3'd0;
  localparam logic [2:0] MODE_SHARED   = 3'd1;
  localparam logic [2:0] MODE_ADV      = 3'd2;
  localparam logic [2:0] MODE_DED_TX   = 3'd3;
  localparam logic [2:0] MODE_DED_RX   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_INIT_FS   = 3'd0;
  localparam logic [2:0] REG_USAGE_TH  = 3'd1;
  localparam logic [2:0] REG_DED_TH    = 3'd2;
  localparam logic [2:0] REG_INTERVAL  = 3'd3;
  localparam logic [2:0] REG_BCAST     = 3'd4;

  // register reset values
  localparam logic [5:0]  RST_INIT_FS  = 6'd16;
  localparam logic [15:0] RST_USAGE_TH = 16'd1;
  localparam logic [15:0] RST_DED_TH   = 16'd10;
  localparam logic [7:0]  RST_INTERVAL = 8'd5;
  localparam logic [15:0] RST_BCAST    = 16'hFFFF;

  localparam logic [15:0] COLL_MIN = 16'd5;

  // slot unit operations
  localparam logic [2:0] UOP_PASS  = 3'd0;
  localparam logic [2:0] UOP_TX    = 3'd1;
  localparam logic [2:0] UOP_RX    = 3'd2;
  localparam logic [2:0] UOP_COLL  = 3'd3;
  localparam logic [2:0] UOP_RCFG  = 3'd4;
  localparam logic [2:0] UOP_CLR   = 3'd5;
  localparam logic [2:0] UOP_FRESH = 3'd6;

  typedef struct packed {
    logic [15:0] tx;
    logic [15:0] rx;
    logic [15:0] coll;
    logic [15:0] att;
    logic [15:0] retry;
    logic [15:0] usage;
    logic [2:0]  mode;
    logic [3:0]  ch;
    logic [15:0] nb;
  } slot_t;

  typedef struct packed {
    logic [5:0]  init_fs;
    logic [15:0] usage_th;
    logic [15:0] ded_th;
    logic [7:0]  interval;
    logic [15:0] bcast;
    logic        load_req;
    logic        intv_req;
  } cfg_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [5:0] cnt_inc6(input logic [5:0] a, input logic [5:0] b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 7'd63) ? 6'd63 : s[5:0];
  endfunction

  function automatic logic [5:0] cnt_dec6(input logic [5:0] a);
    return (a == 6'd0) ? 6'd0 : a - 6'd1;
  endfunction

endpackage

@@ sv/tsch_slot_statistics_reconfig_unit.sv @@
// ----------------------------------------------------------------------------
// tsch_slot_statistics_reconfig_unit
// Per-slot statistics table with sequenced reconfigure, clear and resize
// ----------------------------------------------------------------------------
// record, query, no-op and equal resize: accept, then the result is registered
// reconfigure: slots 1 to frame_size-1, one slot per cycle unless output stalls
// reset stats / resize: sweep of the slots, then an ack; one item at a time
// interval write: not ready for strobe and remainder, one dividend bit a cycle
// reset: table load of all NUM_SLOTS slots, again after initial_frame_size write
module tsch_slot_statistics_reconfig_unit
  import tssr_pkg::*;
#(
  parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_slot_index,
  input  logic [15:0] in_neighbor_address,
  input  logic [7:0]  in_retries,
  input  logic [7:0]  in_new_frame_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [4:0]  out_slot_number,
  output logic [2:0]  out_slot_mode_out,
  output logic [3:0]  out_channel_out,
  output logic [15:0] out_neighbor_out,
  output logic [5:0]  out_active_count,
  output logic [5:0]  out_dedicated_count,
  output logic [5:0]  out_shared_count,
  output logic        out_reconfig_due,
  output logic        out_last
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [5:0] NS6 = 6'(NUM_SLOTS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOAD   = 4'd1;
  localparam logic [3:0] ST_REC    = 4'd2;
  localparam logic [3:0] ST_RCFG   = 4'd3;
  localparam logic [3:0] ST_CLR    = 4'd4;
  localparam logic [3:0] ST_GROW   = 4'd5;
  localparam logic [3:0] ST_SHRINK = 4'd6;
  localparam logic [3:0] ST_DONE   = 4'd7;
  localparam logic [3:0] ST_ACK    = 4'd8;
  localparam logic [3:0] ST_MODC   = 4'd9;

  cfg_t cfg;

  tssr_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  function automatic logic [5:0] clamp_fs(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > NS6)   return NS6;
    return v;
  endfunction

  slot_t       tab_r [NUM_SLOTS];
  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt, end_r, end_nxt;
  logic [2:0]  cmd_r;
  logic [7:0]  sidx_r, retries_r;
  logic [15:0] nb_r;
  logic [5:0]  fs_r, fs_nxt, act_r, act_nxt, ded_r, ded_nxt, shr_r, shr_nxt;
  logic [15:0] cc_r, cc_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;

  logic [IW-1:0] rd_idx;
  slot_t       cur, unit_nxt, wr_slot;
  logic [2:0]  uop, ukind;
  logic        uhit, wr_en;

  logic        out_free, emit;
  logic [2:0]  e_kind, e_mode;
  logic [4:0]  e_slot;
  logic [3:0]  e_ch;
  logic [15:0] e_nb;
  logic        due;

  logic        out_valid_r;
  logic [2:0]  o_kind_r, o_mode_r;
  logic [4:0]  o_slot_r;
  logic [3:0]  o_ch_r;
  logic [15:0] o_nb_r;
  logic [5:0]  o_act_r, o_ded_r, o_shr_r;
  logic        o_due_r, o_last_r;

  logic        ok, accept;
  logic [5:0]  req_fs, ld_fs;
  logic [8:0]  rem_sh, phase_inc;
  logic [5:0]  fs_grow;

  assign ok       = sidx_r < 8'(NUM_SLOTS);
  // a register strobe takes over the sequencer in the next cycle
  assign in_ready = (state_r == ST_IDLE) && !cfg.load_req && !cfg.intv_req;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_idx   = (state_r == ST_REC) ? sidx_r[IW-1:0] : ptr_r[IW-1:0];
  assign cur      = tab_r[rd_idx];
  assign due      = (cfg.interval != 8'd0) && (cc_r != 16'd0) && (phase_r == 8'd0);
  assign req_fs   = (in_new_frame_size > 8'(NUM_SLOTS)) ? NS6 : in_new_frame_size[5:0];
  assign ld_fs    = clamp_fs(cfg.init_fs);
  assign rem_sh   = {phase_r, cc_r[bit_r]};
  assign phase_inc = {1'b0, phase_r} + 9'd1;
  assign fs_grow  = req_fs - fs_r;

  always_comb begin
    unique case (state_r)
      ST_REC: begin
        unique case (cmd_r)
          CMD_TX:   uop = UOP_TX;
          CMD_RX:   uop = UOP_RX;
          CMD_COLL: uop = UOP_COLL;
          default:  uop = UOP_PASS;
        endcase
      end
      ST_RCFG:          uop = UOP_RCFG;
      ST_CLR:           uop = UOP_CLR;
      ST_LOAD, ST_GROW: uop = UOP_FRESH;
      default:          uop = UOP_PASS;
    endcase
  end

  tssr_slot_unit #(.NUM_CHANNELS(NUM_CHANNELS)) u_unit (
    .uop, .cur, .cfg, .nb_in(nb_r), .retries(retries_r),
    .nxt(unit_nxt), .hit(uhit), .kind(ukind)
  );

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    end_nxt   = end_r;
    fs_nxt    = fs_r;
    act_nxt   = act_r;
    ded_nxt   = ded_r;
    shr_nxt   = shr_r;
    cc_nxt    = cc_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    wr_en     = 1'b0;
    wr_slot   = unit_nxt;
    emit      = 1'b0;
    e_kind    = EV_ACK;
    e_slot    = 5'd0;
    e_mode    = MODE_INACTIVE;
    e_ch      = 4'd0;
    e_nb      = 16'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_RCFG: begin
              ptr_nxt   = CW'(1);
              state_nxt = ST_RCFG;
            end
            CMD_RSTAT: begin
              ptr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            CMD_RESIZE: begin
              fs_nxt = req_fs;
              priority if (req_fs > fs_r) begin
                ptr_nxt   = CW'(fs_r);
                end_nxt   = CW'(req_fs);
                act_nxt   = cnt_inc6(act_r, fs_grow);
                shr_nxt   = cnt_inc6(shr_r, fs_grow);
                state_nxt = ST_GROW;
              end else if (req_fs < fs_r) begin
                ptr_nxt   = CW'(req_fs);
                end_nxt   = CW'(fs_r);
                state_nxt = ST_SHRINK;
              end else begin
                state_nxt = ST_ACK;
              end
            end
            CMD_NOP: state_nxt = ST_ACK;
            default: state_nxt = ST_REC;
          endcase
        end
      end
      ST_REC: begin
        if (out_free) begin
          emit      = 1'b1;
          e_slot    = sidx_r[4:0];
          state_nxt = ST_IDLE;
          if (ok) begin
            wr_en  = 1'b1;
            e_mode = (cmd_r == CMD_QUERY && sidx_r >= {2'b00, fs_r}) ?
                     MODE_INACTIVE : unit_nxt.mode;
            e_ch   = unit_nxt.ch;
            e_nb   = unit_nxt.nb;
          end
        end
      end
      ST_RCFG: begin
        if (ptr_r >= CW'(fs_r) || ptr_r >= CW'(NUM_SLOTS)) begin
          state_nxt = ST_DONE;
        end else if (!uhit) begin
          ptr_nxt = ptr_r + CW'(1);
        end else if (out_free) begin
          wr_en   = 1'b1;
          emit    = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
          e_kind  = ukind;
          e_slot  = 5'(ptr_r);
          e_mode  = unit_nxt.mode;
          e_ch    = unit_nxt.ch;
          e_nb    = unit_nxt.nb;
          if (ukind == EV_DEACT) begin
            act_nxt = cnt_dec6(act_r);
          end else if (ukind == EV_DED) begin
            ded_nxt = cnt_inc6(ded_r, 6'd1);
            shr_nxt = cnt_dec6(shr_r);
          end
        end
      end
      ST_CLR: begin
        if (ptr_r >= CW'(fs_r)) begin
          if (cc_r != 16'hFFFF) begin
            cc_nxt    = cc_r + 16'd1;
            phase_nxt = (phase_inc == {1'b0, cfg.interval}) ? 8'd0 : phase_inc[7:0];
          end
          state_nxt = ST_ACK;
        end else begin
          wr_en   = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      ST_GROW, ST_LOAD: begin
        if (ptr_r >= end_r) begin
          state_nxt = (state_r == ST_LOAD) ? ST_IDLE : ST_ACK;
        end else begin
          wr_en   = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
          if (state_r == ST_LOAD) begin
            priority if (ptr_r == '0)        wr_slot.mode = MODE_ADV;
            else if (ptr_r < CW'(fs_r))      wr_slot.mode = MODE_SHARED;
            else                             wr_slot.mode = MODE_INACTIVE;
          end
        end
      end
      ST_SHRINK: begin
        if (ptr_r >= end_r) begin
          state_nxt = ST_ACK;
        end else begin
          wr_en        = 1'b1;
          wr_slot      = cur;
          wr_slot.mode = MODE_INACTIVE;
          ptr_nxt      = ptr_r + CW'(1);
          if (cur.mode != MODE_INACTIVE) begin
            act_nxt = cnt_dec6(act_r);
            if (cur.mode == MODE_DED_TX || cur.mode == MODE_DED_RX)
              ded_nxt = cnt_dec6(ded_r);
            else
              shr_nxt = cnt_dec6(shr_r);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = EV_DONE;
          state_nxt = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MODC: begin
        // restoring remainder of cycle count by the interval, msb first
        phase_nxt = (rem_sh >= {1'b0, cfg.interval}) ?
                    8'(rem_sh - {1'b0, cfg.interval}) : rem_sh[7:0];
        bit_nxt   = bit_r - 4'd1;
        if (bit_r == 4'd0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // initial_frame_size and interval writes override the sequencer
    if (cfg.load_req) begin
      state_nxt = ST_LOAD;
      ptr_nxt   = '0;
      end_nxt   = CW'(NUM_SLOTS);
      fs_nxt    = ld_fs;
      act_nxt   = ld_fs;
      shr_nxt   = ld_fs - 6'd1;
      ded_nxt   = 6'd0;
      cc_nxt    = 16'd0;
      phase_nxt = 8'd0;
    end else if (cfg.intv_req && state_r != ST_LOAD) begin
      // a running table load already leaves the cycle count and phase at zero
      state_nxt = ST_MODC;
      phase_nxt = 8'd0;
      bit_nxt   = 4'd15;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ptr_r       <= '0;
      end_r       <= CW'(NUM_SLOTS);
      fs_r        <= clamp_fs(RST_INIT_FS);
      act_r       <= clamp_fs(RST_INIT_FS);
      shr_r       <= clamp_fs(RST_INIT_FS) - 6'd1;
      ded_r       <= 6'd0;
      cc_r        <= 16'd0;
      phase_r     <= 8'd0;
      bit_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      end_r       <= end_nxt;
      fs_r        <= fs_nxt;
      act_r       <= act_nxt;
      ded_r       <= ded_nxt;
      shr_r       <= shr_nxt;
      cc_r        <= cc_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      sidx_r    <= in_slot_index;
      nb_r      <= in_neighbor_address;
      retries_r <= in_retries;
    end
    if (wr_en) tab_r[rd_idx] <= wr_slot;
    if (emit) begin
      o_kind_r <= e_kind;
      o_slot_r <= e_slot;
      o_mode_r <= e_mode;
      o_ch_r   <= e_ch;
      o_nb_r   <= e_nb;
      o_act_r  <= act_nxt;
      o_ded_r  <= ded_nxt;
      o_shr_r  <= shr_nxt;
      o_due_r  <= due;
      o_last_r <= (state_r != ST_RCFG);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = o_kind_r;
  assign out_slot_number     = o_slot_r;
  assign out_slot_mode_out   = o_mode_r;
  assign out_channel_out     = o_ch_r;
  assign out_neighbor_out    = o_nb_r;
  assign out_active_count    = o_act_r;
  assign out_dedicated_count = o_ded_r;
  assign out_shared_count    = o_shr_r;
  assign out_reconfig_due    = o_due_r;
  assign out_last            = o_last_r;

endmodule

@@ sv/tssr_cfg.sv @@
// ----------------------------------------------------------------------------
// tssr_cfg
// APB register file with reload and interval change strobes
// ----------------------------------------------------------------------------
module tssr_cfg
  import tssr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [5:0]  init_fs_r;
  logic [15:0] usage_th_r;
  logic [15:0] ded_th_r;
  logic [7:0]  interval_r;
  logic [15:0] bcast_r;
  logic [2:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_fs_r  <= RST_INIT_FS;
      usage_th_r <= RST_USAGE_TH;
      ded_th_r   <= RST_DED_TH;
      interval_r <= RST_INTERVAL;
      bcast_r    <= RST_BCAST;
    end else if (wr) begin
      unique case (idx)
        REG_INIT_FS:  init_fs_r  <= pwdata[5:0];
        REG_USAGE_TH: usage_th_r <= pwdata[15:0];
        REG_DED_TH:   ded_th_r   <= pwdata[15:0];
        REG_INTERVAL: interval_r <= pwdata[7:0];
        REG_BCAST:    bcast_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INIT_FS:  prdata = {26'd0, init_fs_r};
      REG_USAGE_TH: prdata = {16'd0, usage_th_r};
      REG_DED_TH:   prdata = {16'd0, ded_th_r};
      REG_INTERVAL: prdata = {24'd0, interval_r};
      REG_BCAST:    prdata = {16'd0, bcast_r};
      default:      prdata = 32'd0;
    endcase
  end

  // strobes arrive together with the new register value
  logic load_r, intv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
      intv_r <= 1'b0;
    end else begin
      load_r <= wr && (idx == REG_INIT_FS);
      intv_r <= wr && (idx == REG_INTERVAL);
    end
  end

  assign cfg.init_fs  = init_fs_r;
  assign cfg.usage_th = usage_th_r;
  assign cfg.ded_th   = ded_th_r;
  assign cfg.interval = interval_r;
  assign cfg.bcast    = bcast_r;
  assign cfg.load_req = load_r;
  assign cfg.intv_req = intv_r;

endmodule

@@ sv/tssr_slot_unit.sv @@
// ----------------------------------------------------------------------------
// tssr_slot_unit
// Shared per-slot update and reconfiguration decision unit
// ----------------------------------------------------------------------------
module tssr_slot_unit
  import tssr_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic [2:0]  uop,
  input  slot_t       cur,
  input  cfg_t        cfg,
  input  logic [15:0] nb_in,
  input  logic [7:0]  retries,
  output slot_t       nxt,
  output logic        hit,
  output logic [2:0]  kind
);

  logic [18:0] coll5;
  logic [4:0]  ch_inc;
  logic        latch;

  assign coll5  = {1'b0, cur.coll, 2'b00} + {3'd0, cur.coll};
  assign ch_inc = {1'b0, cur.ch} + 5'd1;
  assign latch  = (nb_in != 16'd0) && (cur.nb == 16'd0);

  always_comb begin
    nxt  = cur;
    hit  = 1'b0;
    kind = EV_ACK;
    unique case (uop)
      UOP_TX: begin
        nxt.tx    = sat_add16(cur.tx, 8'd1);
        nxt.att   = sat_add16(cur.att, 8'd1);
        nxt.usage = sat_add16(cur.usage, 8'd1);
        nxt.retry = sat_add16(cur.retry, retries);
        if (latch) nxt.nb = nb_in;
      end
      UOP_RX: begin
        nxt.rx    = sat_add16(cur.rx, 8'd1);
        nxt.att   = sat_add16(cur.att, 8'd1);
        nxt.usage = sat_add16(cur.usage, 8'd1);
        if (latch) nxt.nb = nb_in;
      end
      UOP_COLL: begin
        nxt.coll = sat_add16(cur.coll, 8'd1);
        nxt.att  = sat_add16(cur.att, 8'd1);
      end
      UOP_RCFG: begin
        priority if (cur.mode == MODE_INACTIVE) begin
        end else if (cur.usage < cfg.usage_th) begin
          nxt.mode = MODE_INACTIVE;
          hit      = 1'b1;
          kind     = EV_DEACT;
        end else if (cur.tx >= cfg.ded_th && cur.mode == MODE_SHARED &&
                     cur.nb != 16'd0 && cur.nb != cfg.bcast) begin
          nxt.mode = MODE_DED_TX;
          hit      = 1'b1;
          kind     = EV_DED;
        end else if (cur.coll > COLL_MIN && coll5 > {3'd0, cur.att}) begin
          nxt.ch = (ch_inc == 5'(NUM_CHANNELS)) ? 4'd0 : ch_inc[3:0];
          hit    = 1'b1;
          kind   = EV_CHAN;
        end
      end
      UOP_CLR: begin
        nxt.tx = '0; nxt.rx = '0; nxt.coll = '0;
        nxt.att = '0; nxt.retry = '0; nxt.usage = '0;
      end
      UOP_FRESH: begin
        nxt      = '0;
        nxt.mode = MODE_SHARED;
      end
      default: ;
    endcase
  end

endmodule
